@@ rtl/core/mgcs_pkg.sv @@
// Shared types, widths and helpers for the MAC grid cell stencil block.
package mgcs_pkg;

    localparam int CELL_W    = 9;
    localparam int VAL_W     = 32;
    localparam int K_W       = 32;
    localparam int HALF_W    = K_W / 2;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam int DIFF_W = VAL_W + 1;           // face or center difference
    localparam int PROD_W = DIFF_W + HALF_W + 1; // one partial product
    localparam int ACC_W  = DIFF_W + K_W;        // full signed product
    localparam int SUM_W  = 50;                  // sum of two shifted products

    localparam int NUM_TAPS = 6;
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam int STEP_W   = 3;
    localparam int LAST_STEP = 5;

    localparam int DEF_MAX_CELLS_X = 256;
    localparam int DEF_MAX_CELLS_Y = 256;

    localparam logic [CELL_W-1:0] CELLS_RST   = CELL_W'(1);
    localparam logic [K_W-1:0]    INV_SP_RST  = K_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_U = 2'd0,
        OP_WRITE_V = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELLS_X = 2'd0,
        REG_CELLS_Y = 2'd1,
        REG_INV_SP_X = 2'd2,
        REG_INV_SP_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_CALC,
        ST_MATH,
        ST_FLAG
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-VAL_W:0] top;
        top = v[SUM_W-1:VAL_W-1];
        if (top == '0 || top == '1)
            return v[VAL_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

endpackage

@@ rtl/core/mgcs_face_mem.sv @@
// Single-port face store with a registered read.
module mgcs_face_mem
    import mgcs_pkg::*;
#(
    parameter int DEPTH = (DEF_MAX_CELLS_X + 1) * DEF_MAX_CELLS_Y,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [VAL_W-1:0] wdata,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ rtl/core/mgcs_math.sv @@
// Spacing multiplies for divergence and curl, split into 16-bit partial products.
module mgcs_math
    import mgcs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dx_div,
    input  logic signed [DIFF_W-1:0] dy_div,
    input  logic signed [DIFF_W-1:0] dx_curl,
    input  logic signed [DIFF_W-1:0] dy_curl,
    input  logic [K_W-1:0]           k_x,
    input  logic [K_W-1:0]           k_y,
    output logic                     done,
    output logic signed [VAL_W-1:0]  div_value,
    output logic signed [VAL_W-1:0]  curl_value
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [VAL_W-1:0]  div_reg, curl_reg;

    logic signed [DIFF_W-1:0] op_x, op_y;
    logic [HALF_W-1:0]        half_x, half_y;
    logic signed [PROD_W-1:0] mul_x, mul_y;
    logic signed [SUM_W-1:0]  div_sum, curl_sum;

    // steps 0/1: divergence low/high half of k, steps 2/3: curl
    always_comb begin
        op_x   = step_reg[1] ? dx_curl : dx_div;
        op_y   = step_reg[1] ? dy_curl : dy_div;
        half_x = step_reg[0] ? k_x[K_W-1:HALF_W] : k_x[HALF_W-1:0];
        half_y = step_reg[0] ? k_y[K_W-1:HALF_W] : k_y[HALF_W-1:0];
        mul_x  = PROD_W'(op_x) * PROD_W'($signed({1'b0, half_x}));
        mul_y  = PROD_W'(op_y) * PROD_W'($signed({1'b0, half_y}));
        div_sum  = SUM_W'(acc_x_reg >>> 16) + SUM_W'(acc_y_reg >>> 16);
        curl_sum = SUM_W'(acc_x_reg >>> 17) - SUM_W'(acc_y_reg >>> 17);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(LAST_STEP)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            prod_x_reg <= mul_x;
            prod_y_reg <= mul_y;
            unique case (step_reg)
                3'd1, 3'd3: begin
                    acc_x_reg <= ACC_W'(prod_x_reg);
                    acc_y_reg <= ACC_W'(prod_y_reg);
                    if (step_reg == 3'd3) begin
                        div_reg <= sat32(div_sum);
                    end
                end
                3'd2, 3'd4: begin
                    acc_x_reg <= acc_x_reg + (ACC_W'(prod_x_reg) <<< HALF_W);
                    acc_y_reg <= acc_y_reg + (ACC_W'(prod_y_reg) <<< HALF_W);
                end
                3'd5: begin
                    curl_reg <= sat32(curl_sum);
                end
                default: begin
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign div_value  = div_reg;
    assign curl_value = curl_reg;

endmodule

@@ rtl/core/mac_grid_cell_stencil.sv @@
// Top level: staggered velocity grid with per-cell center, divergence and curl queries.
// Query: no new request is taken until the result is loaded into the output
//   register; six U and six V words are read through the single port of each face
//   store, then the spacing multiplies run on two 33x17 multipliers.
// Face write: done in ST_WRITE. Out-of-range query: flagged via ST_FLAG. Unused operation: dropped.
// Reset (synchronous, aresetn low): control and configuration registers return to
//   defaults; face stores are not cleared and hold undefined data until written.
module mac_grid_cell_stencil
    import mgcs_pkg::*;
#(
    parameter int MAX_CELLS_X = DEF_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = DEF_MAX_CELLS_Y
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic [CELL_W-1:0]       s_col,
    input  logic [CELL_W-1:0]       s_row,
    input  logic signed [VAL_W-1:0] s_face_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_center_u,
    output logic signed [VAL_W-1:0] m_center_v,
    output logic signed [VAL_W-1:0] m_div_value,
    output logic signed [VAL_W-1:0] m_curl_value,
    output logic                    m_out_of_range
);

    localparam int U_STRIDE = MAX_CELLS_X + 1;
    localparam int U_DEPTH  = U_STRIDE * MAX_CELLS_Y;
    localparam int U_AW     = $clog2(U_DEPTH);
    localparam int V_STRIDE = MAX_CELLS_X;
    localparam int V_DEPTH  = V_STRIDE * (MAX_CELLS_Y + 1);
    localparam int V_AW     = $clog2(V_DEPTH);

    // configuration
    logic [CELL_W-1:0] cells_x_reg, cells_y_reg;
    logic [K_W-1:0]    inv_x_reg, inv_y_reg;
    logic [CELL_W-1:0] nx, ny;

    // current transaction
    op_t                     op_reg;
    logic [CELL_W-1:0]       col_reg, row_reg;
    logic signed [VAL_W-1:0] val_reg;

    state_t            state_reg, state_next;
    logic [TAP_W-1:0]  cnt_reg, cnt_next;
    logic              load_out, math_start;

    logic u_write_ok, v_write_ok, query_ok;

    // face addressing
    logic [CELL_W-1:0] il, ir, jb, jt, c1, r1;
    logic [CELL_W-1:0] u_col, u_row, v_col, v_row;
    logic [U_AW-1:0]   u_addr;
    logic [V_AW-1:0]   v_addr;
    logic              u_en, u_we, v_en, v_we;
    logic [VAL_W-1:0]  u_rdata, v_rdata;

    logic             rd_vld_reg;
    logic [TAP_W-1:0] rd_tap_reg;
    logic signed [VAL_W-1:0] u_word_reg [NUM_TAPS];
    logic signed [VAL_W-1:0] v_word_reg [NUM_TAPS];

    logic signed [DIFF_W-1:0] u01, v01, u23, u45, v23, v45;
    logic signed [VAL_W-1:0]  cu_reg, cv_reg;
    logic signed [DIFF_W-1:0] dux_reg, dvy_reg, dcx_reg, dcy_reg;

    logic                    math_done;
    logic signed [VAL_W-1:0] math_div, math_curl;

    logic                    m_valid_reg;
    logic                    out_free;
    logic signed [VAL_W-1:0] out_cu_reg, out_cv_reg, out_div_reg, out_curl_reg;
    logic                    out_oor_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_x_reg <= CELLS_RST;
            cells_y_reg <= CELLS_RST;
            inv_x_reg   <= INV_SP_RST;
            inv_y_reg   <= INV_SP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CELLS_X:  cells_x_reg <= cfg_wr_data[CELL_W-1:0];
                REG_CELLS_Y:  cells_y_reg <= cfg_wr_data[CELL_W-1:0];
                REG_INV_SP_X: inv_x_reg   <= cfg_wr_data[K_W-1:0];
                REG_INV_SP_Y: inv_y_reg   <= cfg_wr_data[K_W-1:0];
            endcase
        end
    end

    // zero acts as one, anything above the build maximum acts as the maximum
    always_comb begin
        if (cells_x_reg == '0)
            nx = CELL_W'(1);
        else if (int'(cells_x_reg) > MAX_CELLS_X)
            nx = CELL_W'(MAX_CELLS_X);
        else
            nx = cells_x_reg;
        if (cells_y_reg == '0)
            ny = CELL_W'(1);
        else if (int'(cells_y_reg) > MAX_CELLS_Y)
            ny = CELL_W'(MAX_CELLS_Y);
        else
            ny = cells_y_reg;
    end

    assign u_write_ok = (s_col <= nx) && (s_row < ny);
    assign v_write_ok = (s_col < nx) && (s_row <= ny);
    assign query_ok   = (s_col < nx) && (s_row < ny);
    assign out_free   = !m_valid_reg || m_ready;

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        math_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    unique case (s_operation)
                        OP_WRITE_U: state_next = u_write_ok ? ST_WRITE : ST_IDLE;
                        OP_WRITE_V: state_next = v_write_ok ? ST_WRITE : ST_IDLE;
                        OP_QUERY:   state_next = query_ok ? ST_READ : ST_FLAG;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: begin
                state_next = ST_IDLE;
            end
            ST_READ: begin
                cnt_next = cnt_reg + TAP_W'(1);
                if (cnt_reg == TAP_W'(NUM_TAPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                math_start = 1'b1;
                state_next = ST_MATH;
            end
            ST_MATH: begin
                if (math_done && out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLAG: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= op_t'(s_operation);
            col_reg <= s_col;
            row_reg <= s_row;
            val_reg <= s_face_value;
        end
    end

    // neighbor cells, clamped to the queried cell at the grid edge
    always_comb begin
        c1 = col_reg + CELL_W'(1);
        r1 = row_reg + CELL_W'(1);
        il = (col_reg == '0) ? col_reg : col_reg - CELL_W'(1);
        jb = (row_reg == '0) ? row_reg : row_reg - CELL_W'(1);
        ir = ({1'b0, col_reg} + 10'd1 < {1'b0, nx}) ? c1 : col_reg;
        jt = ({1'b0, row_reg} + 10'd1 < {1'b0, ny}) ? r1 : row_reg;
    end

    // tap order: own faces, then top / right neighbor, then bottom / left neighbor
    always_comb begin
        u_col = col_reg;
        u_row = row_reg;
        v_col = col_reg;
        v_row = row_reg;
        if (state_reg == ST_READ) begin
            unique case (cnt_reg)
                3'd0: begin
                    u_col = col_reg; u_row = row_reg;
                    v_col = col_reg; v_row = row_reg;
                end
                3'd1: begin
                    u_col = c1;      u_row = row_reg;
                    v_col = col_reg; v_row = r1;
                end
                3'd2: begin
                    u_col = col_reg; u_row = jt;
                    v_col = ir;      v_row = row_reg;
                end
                3'd3: begin
                    u_col = c1;      u_row = jt;
                    v_col = ir;      v_row = r1;
                end
                3'd4: begin
                    u_col = col_reg; u_row = jb;
                    v_col = il;      v_row = row_reg;
                end
                3'd5: begin
                    u_col = c1;      u_row = jb;
                    v_col = il;      v_row = r1;
                end
                default: begin
                end
            endcase
        end
        u_addr = U_AW'(int'(u_row) * U_STRIDE + int'(u_col));
        v_addr = V_AW'(int'(v_row) * V_STRIDE + int'(v_col));
        u_we = (state_reg == ST_WRITE) && (op_reg == OP_WRITE_U);
        v_we = (state_reg == ST_WRITE) && (op_reg == OP_WRITE_V);
        u_en = (state_reg == ST_READ) || u_we;
        v_en = (state_reg == ST_READ) || v_we;
    end

    mgcs_face_mem #(
        .DEPTH (U_DEPTH),
        .AW    (U_AW)
    ) u_faces (
        .aclk  (aclk),
        .en    (u_en),
        .we    (u_we),
        .addr  (u_addr),
        .wdata (val_reg),
        .rdata (u_rdata)
    );

    mgcs_face_mem #(
        .DEPTH (V_DEPTH),
        .AW    (V_AW)
    ) v_faces (
        .aclk  (aclk),
        .en    (v_en),
        .we    (v_we),
        .addr  (v_addr),
        .wdata (val_reg),
        .rdata (v_rdata)
    );

    // read data shows up in the cycle after the address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge aclk) begin
        rd_tap_reg <= cnt_reg;
        if (rd_vld_reg) begin
            u_word_reg[rd_tap_reg] <= u_rdata;
            v_word_reg[rd_tap_reg] <= v_rdata;
        end
    end

    // centers are floor of the half sum, i.e. the sum shifted right by one
    always_comb begin
        u01 = DIFF_W'(u_word_reg[0]) + DIFF_W'(u_word_reg[1]);
        v01 = DIFF_W'(v_word_reg[0]) + DIFF_W'(v_word_reg[1]);
        u23 = DIFF_W'(u_word_reg[2]) + DIFF_W'(u_word_reg[3]);
        u45 = DIFF_W'(u_word_reg[4]) + DIFF_W'(u_word_reg[5]);
        v23 = DIFF_W'(v_word_reg[2]) + DIFF_W'(v_word_reg[3]);
        v45 = DIFF_W'(v_word_reg[4]) + DIFF_W'(v_word_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            cu_reg  <= u01[DIFF_W-1:1];
            cv_reg  <= v01[DIFF_W-1:1];
            dux_reg <= DIFF_W'(u_word_reg[1]) - DIFF_W'(u_word_reg[0]);
            dvy_reg <= DIFF_W'(v_word_reg[1]) - DIFF_W'(v_word_reg[0]);
            dcx_reg <= DIFF_W'($signed(v23[DIFF_W-1:1])) - DIFF_W'($signed(v45[DIFF_W-1:1]));
            dcy_reg <= DIFF_W'($signed(u23[DIFF_W-1:1])) - DIFF_W'($signed(u45[DIFF_W-1:1]));
        end
    end

    mgcs_math u_math (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (math_start),
        .dx_div     (dux_reg),
        .dy_div     (dvy_reg),
        .dx_curl    (dcx_reg),
        .dy_curl    (dcy_reg),
        .k_x        (inv_x_reg),
        .k_y        (inv_y_reg),
        .done       (math_done),
        .div_value  (math_div),
        .curl_value (math_curl)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (state_reg == ST_FLAG) begin
                out_cu_reg   <= '0;
                out_cv_reg   <= '0;
                out_div_reg  <= '0;
                out_curl_reg <= '0;
                out_oor_reg  <= 1'b1;
            end else begin
                out_cu_reg   <= cu_reg;
                out_cv_reg   <= cv_reg;
                out_div_reg  <= math_div;
                out_curl_reg <= math_curl;
                out_oor_reg  <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_center_u     = out_cu_reg;
    assign m_center_v     = out_cv_reg;
    assign m_div_value    = out_div_reg;
    assign m_curl_value   = out_curl_reg;
    assign m_out_of_range = out_oor_reg;

endmodule
